[src/tcch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_pkg
// Shared constants, tables and helper functions for the compass heading block.
// ----------------------------------------------------------------------------
package tcch_pkg;

    localparam int ATAN_ENTRIES = 25;
    localparam int QUARTER_TURN = 5760;
    localparam int HALF_TURN    = 11520;
    localparam int FULL_TURN    = 23040;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN   = 3'd4;

    // Rotation CORDIC datapath: Q30 values, angle in 2^-16 of 1/64 degree
    localparam int RW = 34;
    localparam int AW = 32;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    // Vectoring CORDIC datapath: Xh and Yh need about 51 bits plus growth
    localparam int VW = 66;

    // atan(2^-i) in 2^-16 of 1/64 degree
    function automatic logic signed [AW-1:0] atan_at(input int i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                0: r = 32'sd188743680;   1: r = 32'sd111421900;
                2: r = 32'sd58872272;    3: r = 32'sd29884485;
                4: r = 32'sd15000234;    5: r = 32'sd7507429;
                6: r = 32'sd3754631;     7: r = 32'sd1877430;
                8: r = 32'sd938729;      9: r = 32'sd469366;
                10: r = 32'sd234683;     11: r = 32'sd117342;
                12: r = 32'sd58671;      13: r = 32'sd29335;
                14: r = 32'sd14668;      15: r = 32'sd7334;
                16: r = 32'sd3667;       17: r = 32'sd1833;
                18: r = 32'sd917;        19: r = 32'sd458;
                20: r = 32'sd229;        21: r = 32'sd115;
                22: r = 32'sd57;         23: r = 32'sd29;
                24: r = 32'sd14;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        begin
            if (v > 34'sd32767) r = 16'sh7FFF;
            else if (v < -34'sd32768) r = 16'sh8000;
            else r = v[15:0];
            return r;
        end
    endfunction

endpackage

[src/tcch_cal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_cal
// Negation of x, offsets of all axes, gain of y and z, saturation; two register stages.
// ----------------------------------------------------------------------------
module tcch_cal import tcch_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    input  logic signed [15:0] x_off,
    input  logic signed [15:0] y_off,
    input  logic signed [15:0] z_off,
    input  logic        [15:0] y_gain,
    input  logic        [15:0] z_gain,
    output logic signed [15:0] mx,
    output logic signed [15:0] my,
    output logic signed [15:0] mz
);
    logic signed [15:0] mx_reg, mx2_reg;
    logic signed [17:0] dy_reg, dz_reg;
    logic        [15:0] gy_reg, gz_reg;
    logic signed [15:0] my_reg, mz_reg;
    logic signed [34:0] py, pz;
    logic signed [34:0] qy, qz;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg <= sat16(34'(-$signed({{2{raw_x[15]}}, raw_x}) - x_off));
            dy_reg <= 18'(raw_y - 17'(y_off));
            dz_reg <= 18'(raw_z - 17'(z_off));
            gy_reg <= y_gain;
            gz_reg <= z_gain;
        end
    end

    always_comb begin
        py = 35'(dy_reg) * $signed({1'b0, gy_reg});
        pz = 35'(dz_reg) * $signed({1'b0, gz_reg});
        qy = (py >= 0) ? (py >>> 14) : -((-py) >>> 14);
        qz = (pz >= 0) ? (pz >>> 14) : -((-pz) >>> 14);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx2_reg <= mx_reg;
            my_reg  <= sat16(qy[33:0]);
            mz_reg  <= sat16(qz[33:0]);
        end
    end

    assign mx = mx2_reg;
    assign my = my_reg;
    assign mz = mz_reg;
endmodule

[src/tcch_sincos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_sincos
// Pipelined rotation CORDIC: angle in 1/64 degree to Q15 cos and sin.
// ----------------------------------------------------------------------------
module tcch_sincos import tcch_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [16:0] cos_q15,
    output logic signed [16:0] sin_q15
);
    localparam int N = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

    logic signed [RW-1:0] x_reg [0:N];
    logic signed [RW-1:0] y_reg [0:N];
    logic signed [AW-1:0] z_reg [0:N];
    logic                 f_reg [0:N];
    logic signed [16:0]   c_reg, s_reg;
    logic signed [15:0]   fa;
    logic                 fl;
    logic signed [RW-1:0] xr, yr;

    always_comb begin
        fa = angle;
        fl = 1'b0;
        if (angle > 16'sd5760) begin
            fa = angle - 16'sd11520;
            fl = 1'b1;
        end else if (angle < -16'sd5760) begin
            fa = angle + 16'sd11520;
            fl = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= INV_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= {fa, 16'd0};
            f_reg[0] <= fl;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][AW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_at(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_at(i);
                end
            end
        end
    end

    always_comb begin
        xr = (x_reg[N] + RW'(16384)) >>> 15;
        yr = (y_reg[N] + RW'(16384)) >>> 15;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg <= f_reg[N] ? -xr[16:0] : xr[16:0];
            s_reg <= f_reg[N] ? -yr[16:0] : yr[16:0];
        end
    end

    assign cos_q15 = c_reg;
    assign sin_q15 = s_reg;
endmodule

[src/tcch_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_rotate
// Tilt rotation to Xh, Yh in Q30: products then sums, three stages.
// ----------------------------------------------------------------------------
module tcch_rotate import tcch_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] mx,
    input  logic signed [15:0] my,
    input  logic signed [15:0] mz,
    input  logic signed [16:0] cx,
    input  logic signed [16:0] sx,
    input  logic signed [16:0] cy,
    input  logic signed [16:0] sy,
    output logic signed [VW-1:0] xh,
    output logic signed [VW-1:0] yh
);
    logic signed [32:0] p_mxcx_reg, p_mysy_reg, p_mzcy_reg, p_mycy_reg, p_mzsy_reg;
    logic signed [16:0] sx_reg;
    logic signed [33:0] a_reg, yy_reg;
    logic signed [32:0] mxcx2_reg;
    logic signed [16:0] sx2_reg;
    logic signed [VW-1:0] xh_reg, yh_reg;
    logic signed [33:0] ab;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_mxcx_reg <= 33'(mx) * 33'(cx);
            p_mysy_reg <= 33'(my) * 33'(sy);
            p_mzcy_reg <= 33'(mz) * 33'(cy);
            p_mycy_reg <= 33'(my) * 33'(cy);
            p_mzsy_reg <= 33'(mz) * 33'(sy);
            sx_reg     <= sx;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= 34'(p_mysy_reg) - 34'(p_mzcy_reg);
            yy_reg    <= 34'(p_mycy_reg) + 34'(p_mzsy_reg);
            mxcx2_reg <= p_mxcx_reg;
            sx2_reg   <= sx_reg;
        end
    end

    assign ab = a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xh_reg <= (VW'(mxcx2_reg) <<< 15) + VW'(ab * 51'(sx2_reg));
            yh_reg <= VW'(yy_reg) <<< 15;
        end
    end

    assign xh = xh_reg;
    assign yh = yh_reg;
endmodule

[src/tcch_atan2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_atan2
// Pipelined vectoring CORDIC: heading = atan2(y, x) + 180 deg, 1/64 degree.
// ----------------------------------------------------------------------------
module tcch_atan2 import tcch_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [VW-1:0] xin,
    input  logic signed [VW-1:0] yin,
    output logic        [14:0]  heading
);
    localparam int N  = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
    localparam int ZW = 34;

    logic signed [VW-1:0] x_reg [0:N];
    logic signed [VW-1:0] y_reg [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 zero_reg [0:N];
    logic        [14:0]   h_reg;
    logic signed [ZW-1:0] hz;
    logic signed [ZW-1:0] hs;

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (xin == '0) && (yin == '0);
            if (xin[VW-1]) begin
                x_reg[0] <= -xin;
                y_reg[0] <= -yin;
                z_reg[0] <= yin[VW-1] ? -ZW'(HALF_TURN * 65536) : ZW'(HALF_TURN * 65536);
            end else begin
                x_reg[0] <= xin;
                y_reg[0] <= yin;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][VW-1] && (y_reg[i] != '0)) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(atan_at(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(atan_at(i));
                end
            end
        end
    end

    always_comb begin
        hz = (z_reg[N] + ZW'(32768)) >>> 16;
        hs = hz + ZW'(HALF_TURN);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[N]) h_reg <= 15'(HALF_TURN);
            else if (hs < 0) h_reg <= '0;
            else if (hs > ZW'(FULL_TURN)) h_reg <= 15'(FULL_TURN);
            else h_reg <= hs[14:0];
        end
    end

    assign heading = h_reg;
endmodule

[src/tilt_compensated_compass_heading.sv]
`timescale 1ns / 1ps
// Path from input to result word: cal and an alignment delay in parallel with sincos,
// then rotate, then atan2 (CORDIC_STEPS above 25 count as 25). Throughput: one
// word per cycle; the whole datapath advances as one pipeline, stalled by a full
// output register (ready = !m_valid || m_ready).
// Reset: synchronous active-low aresetn clears valid bits and loads register
// defaults (offsets 0, gains 16384). No clearing pass.
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading
// Calibrates a magnetometer sample and computes tilt-compensated heading.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading import tcch_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_raw_x,
    input  logic signed [15:0] s_raw_y,
    input  logic signed [15:0] s_raw_z,
    input  logic signed [14:0] s_tilt_x,
    input  logic signed [14:0] s_tilt_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_cal_x,
    output logic signed [15:0] m_cal_y,
    output logic signed [15:0] m_cal_z,
    output logic        [14:0] m_heading,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int N   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int LAT = 2 * N + 7;
    localparam int CAL_LAT = 2;

    logic signed [15:0] x_off_reg, y_off_reg, z_off_reg;
    logic        [15:0] y_gain_reg, z_gain_reg;
    logic               en;
    logic [LAT-1:0]     vld_reg;

    // calibrated axes delayed to meet the heading
    localparam int DLY = LAT - CAL_LAT;
    logic signed [15:0] dx_reg [0:DLY-1];
    logic signed [15:0] dy_reg [0:DLY-1];
    logic signed [15:0] dz_reg [0:DLY-1];

    // aligning mx/my/mz with the sines
    localparam int ALN = N;
    logic signed [15:0] ax_reg [0:ALN-1];
    logic signed [15:0] ay_reg [0:ALN-1];
    logic signed [15:0] az_reg [0:ALN-1];

    logic signed [15:0] mx, my, mz;
    logic signed [16:0] cx, sx, cy, sy;
    logic signed [VW-1:0] xh, yh;
    logic        [14:0] hd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_off_reg  <= '0;
            y_off_reg  <= '0;
            z_off_reg  <= '0;
            y_gain_reg <= 16'd16384;
            z_gain_reg <= 16'd16384;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_X_OFFSET: x_off_reg  <= cfg_data;
                REG_Y_OFFSET: y_off_reg  <= cfg_data;
                REG_Z_OFFSET: z_off_reg  <= cfg_data;
                REG_Y_GAIN:   y_gain_reg <= cfg_data;
                REG_Z_GAIN:   z_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves when the output slot is free or being taken
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    tcch_cal u_cal (
        .aclk(aclk), .en(en),
        .raw_x(s_raw_x), .raw_y(s_raw_y), .raw_z(s_raw_z),
        .x_off(x_off_reg), .y_off(y_off_reg), .z_off(z_off_reg),
        .y_gain(y_gain_reg), .z_gain(z_gain_reg),
        .mx(mx), .my(my), .mz(mz)
    );

    // negated tilts; 15-bit range widened so -(-16384) fits
    tcch_sincos #(.STEPS(CORDIC_STEPS)) u_sc_x (
        .aclk(aclk), .en(en), .angle(-16'(s_tilt_x)),
        .cos_q15(cx), .sin_q15(sx)
    );

    tcch_sincos #(.STEPS(CORDIC_STEPS)) u_sc_y (
        .aclk(aclk), .en(en), .angle(-16'(s_tilt_y)),
        .cos_q15(cy), .sin_q15(sy)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg[0] <= mx;
            ay_reg[0] <= my;
            az_reg[0] <= mz;
            for (int i = 1; i < ALN; i++) begin
                ax_reg[i] <= ax_reg[i-1];
                ay_reg[i] <= ay_reg[i-1];
                az_reg[i] <= az_reg[i-1];
            end
            dx_reg[0] <= mx;
            dy_reg[0] <= my;
            dz_reg[0] <= mz;
            for (int i = 1; i < DLY; i++) begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
                dz_reg[i] <= dz_reg[i-1];
            end
        end
    end

    tcch_rotate u_rot (
        .aclk(aclk), .en(en),
        .mx(ax_reg[ALN-1]), .my(ay_reg[ALN-1]), .mz(az_reg[ALN-1]),
        .cx(cx), .sx(sx), .cy(cy), .sy(sy),
        .xh(xh), .yh(yh)
    );

    tcch_atan2 #(.STEPS(CORDIC_STEPS)) u_atan (
        .aclk(aclk), .en(en), .xin(xh), .yin(yh), .heading(hd)
    );

    assign m_cal_x   = dx_reg[DLY-1];
    assign m_cal_y   = dy_reg[DLY-1];
    assign m_cal_z   = dz_reg[DLY-1];
    assign m_heading = hd;
endmodule

[sim/tcch_heading_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_heading_checker
// Watches the sample, result and register channels, predicts each result word
// from the calibration settings and compares it field by field.
// ----------------------------------------------------------------------------
module tcch_heading_checker import tcch_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [15:0]   s_raw_x,
    input  logic signed [15:0]   s_raw_y,
    input  logic signed [15:0]   s_raw_z,
    input  logic signed [14:0]   s_tilt_x,
    input  logic signed [14:0]   s_tilt_y,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [15:0]   m_cal_x,
    input  logic signed [15:0]   m_cal_y,
    input  logic signed [15:0]   m_cal_z,
    input  logic        [14:0]   m_heading,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   err_count,
    output int                   pending,
    output int                   checked
);

    typedef struct {
        logic signed [15:0] cal_x;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_z;
        logic        [14:0] heading;
    } heading_word_t;

    localparam longint ANGLE_UNIT = 65536;
    localparam longint CORDIC_K   = 652032874;

    // atan(2^-i), 2^-16 of 1/64 degree
    localparam longint ARCTAN [25] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
        1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29, 14
    };

    heading_word_t      expected_words[$];
    logic signed [15:0] off_x, off_y, off_z;
    logic        [15:0] gain_y, gain_z;

    function automatic longint clamp_s16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint apply_gain(input longint d, input longint g);
        longint p;
        p = d * g;
        return clamp_s16((p >= 0) ? (p >>> 14) : -((-p) >>> 14));
    endfunction

    // rotation CORDIC, Q15 cos/sin of an angle in 1/64 degree
    task automatic tilt_trig(input longint a, output longint c, output longint s);
        bit     flip;
        longint x, y, z, nx;
        flip = 0;
        x = CORDIC_K;
        y = 0;
        if (a > QUARTER_TURN) begin
            a = a - HALF_TURN;
            flip = 1;
        end else if (a < -QUARTER_TURN) begin
            a = a + HALF_TURN;
            flip = 1;
        end
        z = a * ANGLE_UNIT;
        for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ARCTAN[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ARCTAN[i];
            end
            x = nx;
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // vectoring CORDIC: atan2(y, x) + half turn
    function automatic longint compass_angle(input longint x, input longint y);
        longint z, nx, h;
        z = 0;
        if (x == 0 && y == 0) return HALF_TURN;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN * ANGLE_UNIT : -HALF_TURN * ANGLE_UNIT;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ARCTAN[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ARCTAN[i];
            end
            x = nx;
        end
        h = ((z + ANGLE_UNIT / 2) >>> 16) + HALF_TURN;
        if (h < 0) h = 0;
        if (h > FULL_TURN) h = FULL_TURN;
        return h;
    endfunction

    task automatic predict_heading(output heading_word_t w);
        longint mx, my, mz, cx, sx, cy, sy, xh, yh;
        mx = clamp_s16(-longint'(s_raw_x) - longint'(off_x));
        my = apply_gain(longint'(s_raw_y) - longint'(off_y), longint'(gain_y));
        mz = apply_gain(longint'(s_raw_z) - longint'(off_z), longint'(gain_z));
        tilt_trig(-longint'(s_tilt_x), cx, sx);
        tilt_trig(-longint'(s_tilt_y), cy, sy);
        xh = mx * cx * 32768 + my * sy * sx - mz * cy * sx;
        yh = (my * cy + mz * sy) * 32768;
        w.cal_x   = mx[15:0];
        w.cal_y   = my[15:0];
        w.cal_z   = mz[15:0];
        w.heading = 15'(compass_angle(xh, yh));
    endtask

    assign pending = expected_words.size();

    always @(posedge aclk) begin
        heading_word_t w, e;
        if (!aresetn) begin
            off_x  <= '0;
            off_y  <= '0;
            off_z  <= '0;
            gain_y <= 16'd16384;
            gain_z <= 16'd16384;
            expected_words.delete();
            err_count <= 0;
            checked   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_X_OFFSET: off_x  <= cfg_data;
                    REG_Y_OFFSET: off_y  <= cfg_data;
                    REG_Z_OFFSET: off_z  <= cfg_data;
                    REG_Y_GAIN:   gain_y <= cfg_data;
                    REG_Z_GAIN:   gain_z <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_heading(w);
                expected_words.push_back(w);
            end
            if (m_valid && m_ready) begin
                checked <= checked + 1;
                if (expected_words.size() == 0) begin
                    if (err_count < 10)
                        $display("ERROR: unexpected result word at %0t", $realtime);
                    err_count <= err_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (m_cal_x !== e.cal_x || m_cal_y !== e.cal_y ||
                        m_cal_z !== e.cal_z || m_heading !== e.heading) begin
                        if (err_count < 10)
                            $display({"ERROR: word %0d exp x=%0d y=%0d z=%0d hd=%0d",
                                      " got x=%0d y=%0d z=%0d hd=%0d"},
                                     checked, e.cal_x, e.cal_y, e.cal_z, e.heading,
                                     m_cal_x, m_cal_y, m_cal_z, m_heading);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_tilt_compensated_compass_heading.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_compass_heading
// Drives samples and register writes into the compass block through several
// calibration settings; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_compass_heading;
    import tcch_pkg::*;

    localparam int STEPS   = 16;
    localparam int LATENCY = 2 * STEPS + 7;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_valid = 0;
    logic                 s_ready;
    logic signed [15:0]   s_raw_x = 0, s_raw_y = 0, s_raw_z = 0;
    logic signed [14:0]   s_tilt_x = 0, s_tilt_y = 0;
    logic                 m_valid;
    logic                 m_ready = 0;
    logic signed [15:0]   m_cal_x, m_cal_y, m_cal_z;
    logic        [14:0]   m_heading;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [15:0]          cfg_data = 0;

    int err_count, pending, checked;
    int sent_words = 0;
    int cfg_writes = 0;
    bit send_busy = 0;   // no gaps on the sample side while set
    bit recv_busy = 0;   // no stalls on the result side while set
    int stall_left = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    tilt_compensated_compass_heading #(.CORDIC_STEPS(STEPS)) i_dut (.*);

    tcch_heading_checker #(.CORDIC_STEPS(STEPS)) i_checker (.*);

    // result side: random stall after each accepted word
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            n = recv_busy ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                m_ready <= 1'b0;
                stall_left <= n;
            end
        end else if (!m_ready) begin
            if (stall_left <= 1) m_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // one sample word; gap first, then hold valid until accepted
    task automatic send_sample(input logic signed [15:0] rx, ry, rz,
                               input logic signed [14:0] tx, ty);
        int gap;
        gap = send_busy ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_raw_x  <= rx;
        s_raw_y  <= ry;
        s_raw_z  <= rz;
        s_tilt_x <= tx;
        s_tilt_y <= ty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_words++;
        if (sent_words % 48 == 0) begin
            send_busy = ($urandom_range(0, 3) == 0);
            recv_busy = ($urandom_range(0, 3) == 0);
        end
    endtask

    // register writes only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic write_all(input logic [15:0] ox, oy, oz, gy, gz);
        write_reg(REG_X_OFFSET, ox);
        write_reg(REG_Y_OFFSET, oy);
        write_reg(REG_Z_OFFSET, oz);
        write_reg(REG_Y_GAIN, gy);
        write_reg(REG_Z_GAIN, gz);
    endtask

    function automatic logic signed [14:0] any_tilt();
        int r;
        r = $urandom_range(0, 9);
        // bias some tilts onto the right-angle fold
        if (r == 0) return 15'(5760 + $signed($urandom_range(0, 4)) - 2);
        if (r == 1) return 15'(-5760 + $signed($urandom_range(0, 4)) - 2);
        return 15'($signed($urandom_range(0, 23040)) - 11520);
    endfunction

    function automatic logic signed [15:0] any_axis();
        // mostly full range, some small readings near the zero vector
        if ($urandom_range(0, 4) == 0)
            return 16'($signed($urandom_range(0, 600)) - 300);
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_samples(input int n);
        for (int i = 0; i < n; i++)
            send_sample(any_axis(), any_axis(), any_axis(), any_tilt(), any_tilt());
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default calibration
        send_sample(0, 0, 0, 0, 0);                       // zero horizontal vector
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 0, 0);   // -x saturates
        send_sample(16'sh8000, 0, 0, 0, 0);
        send_sample(1000, 0, 0, 0, 0);                    // heading near full turn
        send_sample(-1000, 0, 0, 0, 0);                   // x>0 after negation
        send_sample(1000, -1, 0, 0, 0);                   // heading near 0
        send_sample(1000, 1, 0, 0, 0);
        send_sample(0, 1000, 0, 0, 0);
        send_sample(0, -1000, 0, 0, 0);
        send_sample(500, 700, 900, 15'sd11520, 15'sd11520);
        send_sample(500, 700, 900, -15'sd11520, -15'sd11520);
        send_sample(500, 700, 900, 15'sd5760, -15'sd5760);
        send_sample(500, 700, 900, 15'sd5761, -15'sd5761); // just past a right angle
        send_sample(-800, 300, -900, -15'sd5761, 15'sd5761);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'sd11519, -15'sd1);
        send_sample(123, -456, 789, 15'sd2880, 15'sd8640);
        send_sample(0, 0, 5000, 15'sd2000, 15'sd3000);
        send_sample(0, 0, 5000, 15'sd0, 15'sd0);           // vertical field only
        random_samples(250);

        // random calibration, plus writes to unused indexes
        write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd6, 16'h0000);
        write_reg(3'd7, 16'h5A5A);
        random_samples(250);

        // extremes: offsets at the rails, gains at max
        write_all(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0);
        random_samples(250);

        // zero gains: y and z vanish
        write_all(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'sd4000, 15'sd4000);
        random_samples(150);

        write_all(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                  16'($urandom_range(0, 4000)), 16'($urandom_range(8000, 32768)),
                  16'($urandom_range(8000, 32768)));
        random_samples(150);

        s_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Run covered %0d samples and %0d register writes over five calibrations;",
                 sent_words, cfg_writes);
        $display("%0d result words were compared, %0d left unanswered.", checked, pending);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
src/tcch_pkg.sv
src/tcch_cal.sv
src/tcch_sincos.sv
src/tcch_rotate.sv
src/tcch_atan2.sv
src/tilt_compensated_compass_heading.sv
sim/tcch_heading_checker.sv
sim/tb_tilt_compensated_compass_heading.sv
